// ===== rtl/mbwf_pkg.sv =====
package mbwf_pkg;

  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;
  localparam int MAC_W   = 48;
  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IN_W    = 2 * MAC_W;
  localparam int OUT_W   = 8;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_DEL = 2'd1,
    REQ_CLR = 2'd2,
    REQ_CHK = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_PRESENT   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_INVALID   = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_e;

  typedef struct packed {
    logic hit_a;
    logic hit_d;
    logic free;
  } lane_t;

  typedef struct packed {
    status_e status;
    logic    drop;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic             set_en;
    logic             clr_en;
    logic             clr_all;
    logic [WAY_W-1:0] way;
  } upd_t;

  // bucket count is a power of two, so the reduction is a mask
  function automatic logic [BKT_W-1:0] bucket_f(input logic [MAC_W-1:0] mac);
    logic [9:0] r;
    r = 10'(mac[47:40] ^ mac[7:0]) + 10'(mac[39:32] ^ mac[15:8])
      + 10'(mac[31:24] ^ mac[23:16]);
    return BKT_W'(r % 10'(BUCKETS));
  endfunction

endpackage

// ===== rtl/mbwf_lane.sv =====
module mbwf_lane (
  input  logic [47:0]   entry_a_i,
  input  logic          vld_a_i,
  input  logic [47:0]   entry_d_i,
  input  logic          vld_d_i,
  input  logic [47:0]   mac_a_i,
  input  logic [47:0]   mac_d_i,
  output mbwf_pkg::lane_t lane_o
);
  import mbwf_pkg::*;

  always_comb begin
    lane_o.hit_a = vld_a_i && (entry_a_i == mac_a_i);
    lane_o.hit_d = vld_d_i && (entry_d_i == mac_d_i);
    lane_o.free  = !vld_a_i;
  end

endmodule

// ===== rtl/mbwf_merge.sv =====
module mbwf_merge (
  input  mbwf_pkg::lane_t [mbwf_pkg::WAYS-1:0] lanes_i,
  input  mbwf_pkg::req_e                       req_i,
  input  logic [47:0]                          mac_a_i,
  input  logic                                 filter_en_i,
  input  logic                                 list_mode_i,
  output mbwf_pkg::res_t                       res_o,
  output mbwf_pkg::upd_t                       upd_o
);
  import mbwf_pkg::*;

  logic             hit_a;
  logic             hit_d;
  logic             any_free;
  logic             bad_mac;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    hit_a    = 1'b0;
    hit_d    = 1'b0;
    any_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (lanes_i[i].hit_a) begin
        hit_a   = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (lanes_i[i].hit_d) begin
        hit_d = 1'b1;
      end
      if (lanes_i[i].free) begin
        any_free = 1'b1;
        free_way = WAY_W'(i);
      end
    end
  end

  assign bad_mac = (mac_a_i == '0) || mac_a_i[40];

  always_comb begin
    res_o.drop    = 1'b0;
    res_o.status  = STAT_OK;
    upd_o.set_en  = 1'b0;
    upd_o.clr_en  = 1'b0;
    upd_o.clr_all = 1'b0;
    upd_o.way     = hit_way;
    case (req_i)
      REQ_ADD: begin
        upd_o.way = free_way;
        if (bad_mac) begin
          res_o.status = STAT_INVALID;
        end else if (hit_a) begin
          res_o.status = STAT_PRESENT;
        end else if (any_free) begin
          upd_o.set_en = 1'b1;
        end else begin
          res_o.status = STAT_FULL;
        end
      end
      REQ_DEL: begin
        if (hit_a) begin
          upd_o.clr_en = 1'b1;
        end else begin
          res_o.status = STAT_NOT_FOUND;
        end
      end
      REQ_CLR: begin
        upd_o.clr_all = 1'b1;
      end
      REQ_CHK: begin
        if (filter_en_i) begin
          res_o.drop = list_mode_i ? !(hit_a || hit_d) : (hit_a || hit_d);
        end
      end
      default: begin
        res_o.status = STAT_OK;
      end
    endcase
  end

endmodule

// ===== rtl/mac_black_white_filter.sv =====
// MAC address filter table: 64 buckets of 4 ways, one request at a time.
// The accept edge hashes both addresses and registers the two bucket rows read from the
// address memory; in the evaluate state the 4 way lanes compare in parallel, the merge stage
// forms the result into the output register and applies the add, delete or clear. The
// evaluate state waits while a previous result is still held on the output. s_axis_tuser
// carries the request kind (0 add, 1 delete, 2 clear all, 3 check frame). Registers at
// byte 0 (filter_enable, reset 1) and byte 4 (list_mode, reset 0: black list).
module mac_black_white_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // first_mac[47:0], second_mac[95:48]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // drop_frame[0], status[3:1], zero[7:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbwf_pkg::*;

  state_e           state_q, state_d;
  logic             in_xfer;
  logic             out_free;
  logic             go;
  logic             filt_en_q;
  logic             list_mode_q;
  logic             out_vld_q, out_vld_d;
  res_t             res_q;
  res_t             res;
  upd_t             upd;
  req_e             req_q;
  logic [MAC_W-1:0] mac_a_q;
  logic [MAC_W-1:0] mac_d_q;
  logic [BKT_W-1:0] bkt_a_q;
  logic [BKT_W-1:0] bkt_d_q;
  logic [BKT_W-1:0] bkt_a;
  logic [BKT_W-1:0] bkt_d;
  logic [MAC_W-1:0] rd_a_q [WAYS];
  logic [MAC_W-1:0] rd_d_q [WAYS];
  logic [MAC_W-1:0] mem_q [BUCKETS][WAYS];
  logic [WAYS-1:0]  vld_q [BUCKETS];
  lane_t [WAYS-1:0] lanes;

  // configuration
  assign pready = 1'b1;
  assign prdata = {31'b0, paddr[2] ? list_mode_q : filt_en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q   <= 1'b1;
      list_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        list_mode_q <= pwdata[0];
      end else begin
        filt_en_q <= pwdata[0];
      end
    end
  end

  // control
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_EVAL;
      S_EVAL:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    go            = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_EVAL:  go = out_free;
      default: begin
        s_axis_tready = 1'b0;
        go            = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture and bucket row read
  assign bkt_a = bucket_f(s_axis_tdata[47:0]);
  assign bkt_d = bucket_f(s_axis_tdata[95:48]);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= req_e'(s_axis_tuser);
      mac_a_q <= s_axis_tdata[47:0];
      mac_d_q <= s_axis_tdata[95:48];
      bkt_a_q <= bkt_a;
      bkt_d_q <= bkt_d;
      rd_a_q  <= mem_q[bkt_a];
      rd_d_q  <= mem_q[bkt_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && upd.set_en) begin
      mem_q[bkt_a_q][upd.way] <= mac_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        vld_q[b] <= '0;
      end
    end else if (go) begin
      if (upd.clr_all) begin
        for (int b = 0; b < BUCKETS; b++) begin
          vld_q[b] <= '0;
        end
      end else if (upd.set_en) begin
        vld_q[bkt_a_q][upd.way] <= 1'b1;
      end else if (upd.clr_en) begin
        vld_q[bkt_a_q][upd.way] <= 1'b0;
      end
    end
  end

  // way lanes
  for (genvar w = 0; w < WAYS; w++) begin : g_lane
    mbwf_lane u_lane (
      .entry_a_i (rd_a_q[w]),
      .vld_a_i   (vld_q[bkt_a_q][w]),
      .entry_d_i (rd_d_q[w]),
      .vld_d_i   (vld_q[bkt_d_q][w]),
      .mac_a_i   (mac_a_q),
      .mac_d_i   (mac_d_q),
      .lane_o    (lanes[w])
    );
  end

  mbwf_merge u_merge (
    .lanes_i     (lanes),
    .req_i       (req_q),
    .mac_a_i     (mac_a_q),
    .filter_en_i (filt_en_q),
    .list_mode_i (list_mode_q),
    .res_o       (res),
    .upd_o       (upd)
  );

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (go) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, res_q};

  a_out_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_EVAL))
    else $error("result appeared without evaluation");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EVAL) && !s_axis_tready)
    else $error("second request accepted while one is in flight");

  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && upd.set_en) |=> vld_q[$past(bkt_a_q)][$past(upd.way)])
    else $error("add did not mark its way valid");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && upd.clr_all) |=> (vld_q[$past(bkt_a_q)] == '0))
    else $error("clear left a valid entry");

  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && res.drop) |-> (req_q == REQ_CHK) && (res.status == STAT_OK))
    else $error("drop flagged on a request that is not a check");

endmodule

// ===== verif/mac_black_white_filter_test.sv =====
module mac_black_white_filter_test;
  import mbwf_pkg::*;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          PHASE_ITEMS   = 310;
  localparam int          SLOTS         = BUCKETS * WAYS;
  localparam logic [2:0]  ADDR_ENABLE   = 3'd0;
  localparam logic [2:0]  ADDR_MODE     = 3'd4;
  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    req_e        kind;
    logic [47:0] src;
    logic [47:0] dst;
  } filter_req_t;

  typedef struct {
    logic    drop;
    status_e status;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_tdata = '0;   // first_mac[47:0], second_mac[95:48]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_axis_tdata;   // drop_frame[0], status[3:1], zero[7:4]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mac_black_white_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // table shadow
  logic [47:0] slot_mac [SLOTS];
  logic        slot_used [SLOTS];
  logic        cfg_enable = 1'b1;
  logic        cfg_white = 1'b0;

  filter_req_t pending_q [$];
  verdict_t    verdict_q [$];
  filter_req_t cur_req;
  logic [47:0] mac_pool [$];

  int sent_n = 0;
  int seen_n = 0;
  int err_n = 0;
  int cyc_n = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic [7:0] ready_pat = 8'hFF;
  int ready_idx = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_mac[i] = '0;
      slot_used[i] = 1'b0;
    end
  end

  function automatic int unsigned home_bucket(logic [47:0] mac);
    int unsigned x0, x1, x2;
    x0 = mac[47:40] ^ mac[7:0];
    x1 = mac[39:32] ^ mac[15:8];
    x2 = mac[31:24] ^ mac[23:16];
    return (x0 + x1 + x2) % BUCKETS;
  endfunction

  function automatic int lookup_slot(logic [47:0] mac);
    int unsigned base;
    int found;
    base = home_bucket(mac) * WAYS;
    found = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (found < 0 && slot_used[base + w] && slot_mac[base + w] == mac) found = base + w;
    end
    return found;
  endfunction

  function automatic verdict_t filter_table_step(filter_req_t rq);
    verdict_t v;
    int unsigned base;
    int s;
    logic hit;
    logic placed;
    v.drop = 1'b0;
    v.status = STAT_OK;
    case (rq.kind)
      REQ_ADD: begin
        if (rq.src == '0 || rq.src[40]) begin
          v.status = STAT_INVALID;
        end else if (lookup_slot(rq.src) >= 0) begin
          v.status = STAT_PRESENT;
        end else begin
          base = home_bucket(rq.src) * WAYS;
          placed = 1'b0;
          for (int w = 0; w < WAYS; w++) begin
            if (!placed && !slot_used[base + w]) begin
              slot_used[base + w] = 1'b1;
              slot_mac[base + w] = rq.src;
              placed = 1'b1;
            end
          end
          v.status = placed ? STAT_OK : STAT_FULL;
        end
      end
      REQ_DEL: begin
        s = lookup_slot(rq.src);
        if (s < 0) v.status = STAT_NOT_FOUND;
        else slot_used[s] = 1'b0;
      end
      REQ_CLR: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      end
      default: begin
        if (cfg_enable) begin
          hit = (lookup_slot(rq.src) >= 0) || (lookup_slot(rq.dst) >= 0);
          v.drop = cfg_white ? !hit : hit;
        end
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
    $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cyc_n);
    err_n++;
  endtask

  // unicast address landing in a chosen bucket
  function automatic logic [47:0] mac_in_bucket(int unsigned bkt);
    logic [7:0] b [6];
    int unsigned part;
    int unsigned x;
    for (int k = 0; k < 5; k++) b[k] = 8'($urandom);
    b[0][0] = 1'b0;
    part = (b[1] ^ b[4]) + (b[2] ^ b[3]);
    x = ((bkt % BUCKETS) + 1024 - part) % BUCKETS + BUCKETS * $urandom_range(0, 256 / BUCKETS - 1);
    b[5] = 8'(x) ^ b[0];
    return {b[0], b[1], b[2], b[3], b[4], b[5]};
  endfunction

  function automatic logic [47:0] pick_mac();
    int unsigned r;
    logic [47:0] m;
    r = $urandom_range(0, 99);
    m = {16'($urandom), 32'($urandom)};
    if (r < 75) begin
      m = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: m = '0;
        1: m = MAC_BROADCAST;
        2: m[40] = 1'b1;
        default: ;
      endcase
    end else begin
      m = mac_in_bucket($urandom_range(0, BUCKETS - 1));
    end
    return m;
  endfunction

  task automatic queue_req(input req_e kind, input logic [47:0] src, input logic [47:0] dst);
    filter_req_t rq;
    rq.kind = kind;
    rq.src = src;
    rq.dst = dst;
    pending_q.push_back(rq);
    sent_n++;
  endtask

  task automatic wait_drained();
    while (seen_n < sent_n) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_ENABLE) cfg_enable = value[0];
    else if (addr == ADDR_MODE) cfg_white = value[0];
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [2:0] addr, input logic want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'b0, want}) report_mismatch("register readback", {47'b0, want}, 48'(got));
    @(posedge clk_i);
  endtask

  task automatic set_filter(input logic en, input logic white);
    apb_write(ADDR_ENABLE, {31'($urandom), en});
    apb_write(ADDR_MODE, {31'($urandom), white});
    apb_check(ADDR_ENABLE, en);
    apb_check(ADDR_MODE, white);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) verdict_q.push_back(filter_table_step(cur_req));
      if (s_valid && !s_axis_tready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        s_valid <= 1'b1;
        s_tdata <= {cur_req.dst, cur_req.src};
        s_tuser <= cur_req.kind;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern reloaded once all of its bits are used
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result without request", '0, 48'(m_axis_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.drop) report_mismatch("drop_frame", 48'(want.drop),
                                                           48'(m_axis_tdata[0]));
        if (m_axis_tdata[3:1] !== want.status) report_mismatch("status", 48'(want.status),
                                                               48'(m_axis_tdata[3:1]));
      end
      seen_n++;
    end
    if (ready_idx == 7) begin
      ready_idx = 0;
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    end else begin
      ready_idx++;
    end
    m_ready <= ready_pat[ready_idx];
  end

  always @(posedge clk_i) begin
    cyc_n++;
    if (cyc_n > CYCLE_LIMIT) begin
      $display("mac_black_white_filter_test: errors");
      $finish;
    end
  end

  initial begin
    logic [47:0] mac_a;
    logic [47:0] crowd [5];
    logic        en_set [5];
    logic        white_set [5];
    int unsigned r;
    req_e        kind;

    en_set = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    white_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    for (int t = 0; t < 4; t++) begin
      r = $urandom_range(0, BUCKETS - 1);
      for (int k = 0; k < 7; k++) mac_pool.push_back(mac_in_bucket(r));
    end
    for (int k = 0; k < 12; k++) mac_pool.push_back(mac_in_bucket($urandom_range(0, BUCKETS - 1)));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_filter(1'b1, 1'b0);
    @(posedge clk_i);

    // directed: invalid adds, duplicate, full bucket, way reuse, missing deletes, checks
    mac_a = 48'hFEFF_FFFF_FFFF;
    for (int k = 0; k < 5; k++) crowd[k] = mac_in_bucket(40);
    queue_req(REQ_ADD, '0, MAC_BROADCAST);
    queue_req(REQ_ADD, MAC_BROADCAST, '0);
    queue_req(REQ_ADD, 48'h0100_0000_0000, '0);
    queue_req(REQ_ADD, mac_a, '0);
    queue_req(REQ_ADD, mac_a, '0);
    for (int k = 0; k < 5; k++) queue_req(REQ_ADD, crowd[k], '0);
    queue_req(REQ_DEL, crowd[1], MAC_BROADCAST);
    queue_req(REQ_ADD, crowd[4], '0);
    queue_req(REQ_CHK, 48'h0200_0000_0001, crowd[4]);
    queue_req(REQ_DEL, 48'h0200_0000_0002, '0);
    queue_req(REQ_DEL, '0, '0);
    queue_req(REQ_DEL, MAC_BROADCAST, '0);
    queue_req(REQ_CHK, mac_a, MAC_BROADCAST);
    queue_req(REQ_CHK, '0, '0);
    queue_req(REQ_CHK, MAC_BROADCAST, MAC_BROADCAST);
    queue_req(REQ_CLR, MAC_BROADCAST, MAC_BROADCAST);
    queue_req(REQ_CHK, mac_a, crowd[0]);
    queue_req(REQ_DEL, mac_a, '0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      set_filter(en_set[p], white_set[p]);
      @(posedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) kind = REQ_ADD;
        else if (r < 60) kind = REQ_DEL;
        else if (r < 97) kind = REQ_CHK;
        else kind = REQ_CLR;
        queue_req(kind, pick_mac(), pick_mac());
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (err_n == 0) begin
      $display("mac_black_white_filter_test: clean");
    end else begin
      $display("mac_black_white_filter_test: errors");
    end
    $finish;
  end

endmodule

// ===== mac_black_white_filter.f =====
rtl/mbwf_pkg.sv
rtl/mbwf_lane.sv
rtl/mbwf_merge.sv
rtl/mac_black_white_filter.sv
verif/mac_black_white_filter_test.sv
